@@ sv/touch_sample_conditioner_macros.svh @@
// Assertion macros for the checker file of the touch conditioner.
`ifndef TOUCH_SAMPLE_CONDITIONER_MACROS_SVH
`define TOUCH_SAMPLE_CONDITIONER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define TSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch conditioner: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define TSC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch conditioner: next-cycle check failed");

`endif

@@ sv/tsc_pkg.sv @@
package tsc_pkg;

   // Sample and result widths
   localparam int SAMPLE_W   = 12;
   localparam int PRES_W     = 13;
   localparam int SIZE_W     = 13;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int DIV_STEPS  = SAMPLE_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

   localparam logic [SAMPLE_W-1:0] FULL_SCALE     = 12'd4095;
   localparam logic [PRES_W-1:0]   PRESS_THRESHOLD = 13'd400;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_ROTATION   = 3'd0;
   localparam logic [2:0] REG_CAL_X_MIN  = 3'd1;
   localparam logic [2:0] REG_CAL_X_MAX  = 3'd2;
   localparam logic [2:0] REG_CAL_Y_MIN  = 3'd3;
   localparam logic [2:0] REG_CAL_Y_MAX  = 3'd4;
   localparam logic [2:0] REG_SCREEN_W   = 3'd5;
   localparam logic [2:0] REG_SCREEN_H   = 3'd6;
   localparam logic [2:0] REG_INVERT     = 3'd7;

   // Rotation codes
   localparam logic [1:0] ROT_QUARTER    = 2'd0;
   localparam logic [1:0] ROT_NONE       = 2'd1;
   localparam logic [1:0] ROT_THREE_QTR  = 2'd2;
   localparam logic [1:0] ROT_HALF       = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILTER,
      ST_MUL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ sv/tsc_divider.sv @@
module tsc_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [tsc_pkg::PROD_W-1:0]        dividend,
   input  logic [tsc_pkg::SAMPLE_W-1:0]      divisor,
   output tsc_pkg::div_status_type           status,
   output logic [tsc_pkg::SAMPLE_W-1:0]      quotient
);
   import tsc_pkg::*;

   // Restoring divider, one quotient bit a cycle. The quotient is known to
   // fit SAMPLE_W bits, so the upper half of the dividend is the first
   // partial remainder.
   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  quo_ff, quo_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SAMPLE_W:0]    shifted;
   logic                 fits;

   // Trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[SAMPLE_W-1]};
      fits    = shifted >= {1'b0, divisor};
   end

   // Next values
   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = dividend[PROD_W-1:SAMPLE_W];
         quo_in   = dividend[SAMPLE_W-1:0];
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? SAMPLE_W'(shifted - {1'b0, divisor}) : shifted[SAMPLE_W-1:0];
         quo_in   = {quo_ff[SAMPLE_W-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

@@ sv/touch_sample_conditioner.sv @@
// Touch sample conditioner.
// Input stream (req_): one beat carries a full set of converter readings,
// two pressure samples and three samples per axis. Result stream (rsp_):
// one beat per input beat with the pressed flag on tuser and the held
// screen, rotated and pressure values on tdata.
// Configuration is an APB-style port, one register per 32-bit word; write
// it only while no beat is in flight.
// Sequencing: a beat below the pressure threshold goes from the filter
// state straight to the done state. For a pressed beat the two screen
// mappings run one after the other through a single multiplier and a
// shared 12-step restoring divider.
// req_tready is high only while the sequencer is idle, so one beat is
// worked on at a time; a finished result waits in the output register, and
// the next beat may be accepted meanwhile. If the receiver stalls, the
// sequencer holds its result until the output register frees.
// Reset (synchronous) restores the register defaults, clears the held
// coordinates and pressure, and empties the output register.
module touch_sample_conditioner (
   input  logic        clock,
   input  logic        reset,
   // x_sample_* / y_sample_* after the two pressure samples, from bit 0 up:
   // pressure_sample_one, pressure_sample_two, x_sample_0, x_sample_1,
   // x_sample_2, y_sample_0, y_sample_1, y_sample_2 (12 bits each)
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   // from bit 0 up: screen_x, screen_y, rotated_x, rotated_y (12 bits each),
   // pressure (13 bits), zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,
   // pressed
   output logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tsc_pkg::*;

   localparam int NUM_SAMPLES = 8;

   // Mean of the closest pair of three samples; ties take the earlier pair
   function automatic logic [SAMPLE_W-1:0] pair_mean(
      input logic [SAMPLE_W-1:0] a,
      input logic [SAMPLE_W-1:0] b,
      input logic [SAMPLE_W-1:0] c
   );
      logic [SAMPLE_W-1:0] dab, dac, dbc;
      logic [SAMPLE_W:0]   total;
      dab = (a >= b) ? a - b : b - a;
      dac = (a >= c) ? a - c : c - a;
      dbc = (b >= c) ? b - c : c - b;
      if (dab <= dac && dab <= dbc) begin
         total = {1'b0, a} + {1'b0, b};
      end else if (dac <= dbc) begin
         total = {1'b0, a} + {1'b0, c};
      end else begin
         total = {1'b0, b} + {1'b0, c};
      end
      return total[SAMPLE_W:1];
   endfunction

   // Largest screen index for a size register, size taken as 1..4096
   function automatic logic [SAMPLE_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] top;
      if (size == '0) begin
         top = '0;
      end else if (size[SIZE_W-1] && size[SIZE_W-2:0] != '0) begin
         top = {1'b0, FULL_SCALE};
      end else begin
         top = size - 1'b1;
      end
      return top[SAMPLE_W-1:0];
   endfunction

   // Configuration registers
   logic [1:0]          rotation_ff;
   logic [SAMPLE_W-1:0] cal_x_min_ff, cal_x_max_ff, cal_y_min_ff, cal_y_max_ff;
   logic [SIZE_W-1:0]   screen_width_ff, screen_height_ff;
   logic [1:0]          invert_axes_ff;
   logic                csr_write;

   // Sequencer and datapath
   state_type           state_ff, state_in;
   logic                axis_ff, axis_in;
   logic [SAMPLE_W-1:0] samples_ff [NUM_SAMPLES];
   logic [PRES_W-1:0]   pres_ff, pres_sum;
   logic                pressed_ff;
   logic [SAMPLE_W-1:0] rot_x_ff, rot_y_ff, rot_x_in, rot_y_in, mean_x, mean_y;
   logic [SAMPLE_W-1:0] scr_x_ff, scr_y_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [SAMPLE_W-1:0] held_scr_x_ff, held_scr_y_ff, held_rot_x_ff, held_rot_y_ff;
   logic [PRES_W-1:0]   held_pres_ff;
   logic                rsp_valid_ff;
   logic                rsp_user_ff;
   logic [63:0]         rsp_data_ff;

   // Axis mapping operands
   logic [SAMPLE_W-1:0] ax_val, ax_lo, ax_hi, ax_top, ax_clamp, ax_diff, ax_range;
   logic [SAMPLE_W-1:0] ax_mapped;
   logic                ax_bad, ax_inv;
   logic                out_free;

   // Shared divider
   logic                   div_start;
   div_status_type         div_status;
   logic [SAMPLE_W-1:0]    div_quotient;

   tsc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (ax_range),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // Configuration writes
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff      <= ROT_NONE;
         cal_x_min_ff     <= '0;
         cal_x_max_ff     <= FULL_SCALE;
         cal_y_min_ff     <= '0;
         cal_y_max_ff     <= FULL_SCALE;
         screen_width_ff  <= 13'd320;
         screen_height_ff <= 13'd240;
         invert_axes_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_ROTATION:  rotation_ff      <= csr_pwdata[1:0];
            REG_CAL_X_MIN: cal_x_min_ff     <= csr_pwdata[SAMPLE_W-1:0];
            REG_CAL_X_MAX: cal_x_max_ff     <= csr_pwdata[SAMPLE_W-1:0];
            REG_CAL_Y_MIN: cal_y_min_ff     <= csr_pwdata[SAMPLE_W-1:0];
            REG_CAL_Y_MAX: cal_y_max_ff     <= csr_pwdata[SAMPLE_W-1:0];
            REG_SCREEN_W:  screen_width_ff  <= csr_pwdata[SIZE_W-1:0];
            REG_SCREEN_H:  screen_height_ff <= csr_pwdata[SIZE_W-1:0];
            REG_INVERT:    invert_axes_ff   <= csr_pwdata[1:0];
            default:       ;
         endcase
      end
   end

   // Register read-back
   always_comb begin
      unique case (csr_paddr[4:2])
         REG_ROTATION:  csr_prdata = {30'd0, rotation_ff};
         REG_CAL_X_MIN: csr_prdata = {20'd0, cal_x_min_ff};
         REG_CAL_X_MAX: csr_prdata = {20'd0, cal_x_max_ff};
         REG_CAL_Y_MIN: csr_prdata = {20'd0, cal_y_min_ff};
         REG_CAL_Y_MAX: csr_prdata = {20'd0, cal_y_max_ff};
         REG_SCREEN_W:  csr_prdata = {19'd0, screen_width_ff};
         REG_SCREEN_H:  csr_prdata = {19'd0, screen_height_ff};
         REG_INVERT:    csr_prdata = {30'd0, invert_axes_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // Pressure, filtering and rotation
   always_comb begin
      pres_sum = {1'b0, samples_ff[0]} + {1'b0, FULL_SCALE} - {1'b0, samples_ff[1]};
      mean_x   = pair_mean(samples_ff[2], samples_ff[3], samples_ff[4]);
      mean_y   = pair_mean(samples_ff[5], samples_ff[6], samples_ff[7]);
      unique case (rotation_ff)
         ROT_QUARTER: begin
            rot_x_in = FULL_SCALE - mean_y;
            rot_y_in = mean_x;
         end
         ROT_NONE: begin
            rot_x_in = mean_x;
            rot_y_in = mean_y;
         end
         ROT_THREE_QTR: begin
            rot_x_in = mean_y;
            rot_y_in = FULL_SCALE - mean_x;
         end
         ROT_HALF: begin
            rot_x_in = FULL_SCALE - mean_x;
            rot_y_in = FULL_SCALE - mean_y;
         end
         default: begin
            rot_x_in = mean_x;
            rot_y_in = mean_y;
         end
      endcase
   end

   // Select the axis in work, clamp into its calibration range and invert the mapped value if asked
   always_comb begin
      ax_val   = axis_ff ? rot_y_ff : rot_x_ff;
      ax_lo    = axis_ff ? cal_y_min_ff : cal_x_min_ff;
      ax_hi    = axis_ff ? cal_y_max_ff : cal_x_max_ff;
      ax_top   = axis_ff ? last_index(screen_height_ff) : last_index(screen_width_ff);
      ax_inv   = axis_ff ? invert_axes_ff[1] : invert_axes_ff[0];
      ax_bad   = ax_hi <= ax_lo;
      ax_range = ax_hi - ax_lo;
      priority if (ax_val < ax_lo) begin
         ax_clamp = ax_lo;
      end else if (ax_val > ax_hi) begin
         ax_clamp = ax_hi;
      end else begin
         ax_clamp = ax_val;
      end
      ax_diff   = ax_clamp - ax_lo;
      ax_mapped = ax_bad ? '0 : div_quotient;
      if (ax_inv) begin
         ax_mapped = ax_top - ax_mapped;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_FILTER;
            end
         end
         ST_FILTER: begin
            axis_in  = 1'b0;
            state_in = (pres_sum >= PRESS_THRESHOLD) ? ST_MUL : ST_DONE;
         end
         ST_MUL:       state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               axis_in  = 1'b1;
               state_in = axis_ff ? ST_DONE : ST_MUL;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE:      req_tready = 1'b1;
         ST_DIV_START: div_start  = 1'b1;
         default:      ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         axis_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         held_scr_x_ff <= '0;
         held_scr_y_ff <= '0;
         held_rot_x_ff <= '0;
         held_rot_y_ff <= '0;
         held_pres_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
         // Load the result and refresh the held values on a press
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (pressed_ff) begin
               held_scr_x_ff <= scr_x_ff;
               held_scr_y_ff <= scr_y_ff;
               held_rot_x_ff <= rot_x_ff;
               held_rot_y_ff <= rot_y_ff;
               held_pres_ff  <= pres_ff;
            end
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         for (int i = 0; i < NUM_SAMPLES; i++) begin
            samples_ff[i] <= req_tdata[i*SAMPLE_W +: SAMPLE_W];
         end
      end
      if (state_ff == ST_FILTER) begin
         pres_ff    <= pres_sum;
         pressed_ff <= pres_sum >= PRESS_THRESHOLD;
         rot_x_ff   <= rot_x_in;
         rot_y_ff   <= rot_y_in;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= ax_diff * ax_top;
      end
      if (state_ff == ST_DIV_WAIT && div_status.done) begin
         if (axis_ff) begin
            scr_y_ff <= ax_mapped;
         end else begin
            scr_x_ff <= ax_mapped;
         end
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_user_ff <= pressed_ff;
         if (pressed_ff) begin
            rsp_data_ff <= {3'd0, pres_ff, rot_y_ff, rot_x_ff, scr_y_ff, scr_x_ff};
         end else begin
            rsp_data_ff <= {3'd0, held_pres_ff, held_rot_y_ff, held_rot_x_ff,
                            held_scr_y_ff, held_scr_x_ff};
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

@@ sv/tsc_checker.sv @@
`include "touch_sample_conditioner_macros.svh"

module tsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tuser
);
   import tsc_pkg::*;

   logic req_beat;
   logic [PRES_W-1:0] rsp_pressure;

   assign req_beat     = req_tvalid && req_tready;
   assign rsp_pressure = rsp_tdata[60:48];

   // A stalled result beat holds still
   `TSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   // The block is busy in the cycle after taking a beat
   `TSC_ASSERT_NXT(a_busy_after_req, clock, reset, req_beat, !req_tready)
   // A pressed result carries a pressure at or above threshold
   `TSC_ASSERT_IMP(a_press_level, clock, reset, rsp_tvalid && rsp_tuser, rsp_pressure >= PRESS_THRESHOLD)
   // A fresh result only appears after the sequencer was working
   `TSC_ASSERT_IMP(a_rsp_after_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind touch_sample_conditioner tsc_checker u_tsc_checker (.*);

@@ tb/touch_report_checker.sv @@
`timescale 1ns / 100ps

module touch_report_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // from bit 0 up: pressure_sample_one, pressure_sample_two, x_sample_0..2,
   // y_sample_0..2 (12 bits each)
   input  logic [95:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // from bit 0 up: screen_x, screen_y, rotated_x, rotated_y, pressure, zero fill
   input  logic [63:0] rsp_tdata,
   // pressed
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          mismatch_count,
   output int          outstanding
);
   import tsc_pkg::*;

   typedef struct packed {
      logic                pressed;
      logic [SAMPLE_W-1:0] screen_x;
      logic [SAMPLE_W-1:0] screen_y;
      logic [SAMPLE_W-1:0] rotated_x;
      logic [SAMPLE_W-1:0] rotated_y;
      logic [PRES_W-1:0]   pressure;
   } touch_report_type;

   // Panel settings as seen on the configuration port
   logic [1:0]          cfg_rotation;
   logic [SAMPLE_W-1:0] cfg_cal_x_min;
   logic [SAMPLE_W-1:0] cfg_cal_x_max;
   logic [SAMPLE_W-1:0] cfg_cal_y_min;
   logic [SAMPLE_W-1:0] cfg_cal_y_max;
   logic [SIZE_W-1:0]   cfg_screen_w;
   logic [SIZE_W-1:0]   cfg_screen_h;
   logic [1:0]          cfg_invert;

   touch_report_type held_report;
   touch_report_type expected_reports[$];
   int               fault_count = 0;
   int               report_index = 0;

   assign mismatch_count = fault_count;

   function automatic logic [SAMPLE_W-1:0] closest_pair_mean(
      input logic [SAMPLE_W-1:0] a, b, c);
      logic [SAMPLE_W-1:0] dab, dac, dbc;
      logic [SAMPLE_W:0]   pair_sum;
      dab = (a >= b) ? a - b : b - a;
      dac = (a >= c) ? a - c : c - a;
      dbc = (b >= c) ? b - c : c - b;
      // ties go to the earlier pair
      if (dab <= dac && dab <= dbc)
         pair_sum = {1'b0, a} + {1'b0, b};
      else if (dac <= dab && dac <= dbc)
         pair_sum = {1'b0, a} + {1'b0, c};
      else
         pair_sum = {1'b0, b} + {1'b0, c};
      return pair_sum[SAMPLE_W:1];
   endfunction

   // Largest screen index; size limited to 1..4096
   function automatic logic [SAMPLE_W-1:0] last_index(input logic [SIZE_W-1:0] size);
      if (size == '0)
         return '0;
      if (size > 13'd4096)
         return FULL_SCALE;
      return SAMPLE_W'(size - 1'b1);
   endfunction

   function automatic logic [SAMPLE_W-1:0] map_axis(
      input logic [SAMPLE_W-1:0] v, lo, hi, top_index);
      logic [SAMPLE_W-1:0] clamped;
      logic [PROD_W-1:0]   span_product;
      if (hi <= lo)
         return '0;
      clamped = (v < lo) ? lo : ((v > hi) ? hi : v);
      span_product = PROD_W'(clamped - lo) * PROD_W'(top_index);
      return SAMPLE_W'(span_product / PROD_W'(hi - lo));
   endfunction

   // Work out the report for one set of readings and refresh the held values
   function automatic touch_report_type condition_readings(input logic [95:0] beat);
      logic [SAMPLE_W-1:0] raw_x, raw_y, rot_x, rot_y, top_x, top_y, col, row;
      logic [PRES_W-1:0]   pres;
      pres = {1'b0, beat[11:0]} + {1'b0, FULL_SCALE} - {1'b0, beat[23:12]};
      held_report.pressed = (pres >= PRESS_THRESHOLD);
      if (held_report.pressed) begin
         raw_x = closest_pair_mean(beat[35:24], beat[47:36], beat[59:48]);
         raw_y = closest_pair_mean(beat[71:60], beat[83:72], beat[95:84]);
         case (cfg_rotation)
            ROT_QUARTER: begin
               rot_x = FULL_SCALE - raw_y;
               rot_y = raw_x;
            end
            ROT_NONE: begin
               rot_x = raw_x;
               rot_y = raw_y;
            end
            ROT_THREE_QTR: begin
               rot_x = raw_y;
               rot_y = FULL_SCALE - raw_x;
            end
            default: begin
               rot_x = FULL_SCALE - raw_x;
               rot_y = FULL_SCALE - raw_y;
            end
         endcase
         top_x = last_index(cfg_screen_w);
         top_y = last_index(cfg_screen_h);
         col = map_axis(rot_x, cfg_cal_x_min, cfg_cal_x_max, top_x);
         row = map_axis(rot_y, cfg_cal_y_min, cfg_cal_y_max, top_y);
         if (cfg_invert[0])
            col = top_x - col;
         if (cfg_invert[1])
            row = top_y - row;
         held_report.screen_x  = col;
         held_report.screen_y  = row;
         held_report.rotated_x = rot_x;
         held_report.rotated_y = rot_y;
         held_report.pressure  = pres;
      end
      return held_report;
   endfunction

   always @(posedge clock) begin
      touch_report_type actual;
      touch_report_type wanted;
      if (reset) begin
         cfg_rotation  = ROT_NONE;
         cfg_cal_x_min = '0;
         cfg_cal_x_max = FULL_SCALE;
         cfg_cal_y_min = '0;
         cfg_cal_y_max = FULL_SCALE;
         cfg_screen_w  = 13'd320;
         cfg_screen_h  = 13'd240;
         cfg_invert    = 2'd0;
         held_report   = '0;
         expected_reports.delete();
         outstanding  <= 0;
      end else begin
         // track register writes
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[4:2])
               REG_ROTATION:  cfg_rotation  = csr_pwdata[1:0];
               REG_CAL_X_MIN: cfg_cal_x_min = csr_pwdata[SAMPLE_W-1:0];
               REG_CAL_X_MAX: cfg_cal_x_max = csr_pwdata[SAMPLE_W-1:0];
               REG_CAL_Y_MIN: cfg_cal_y_min = csr_pwdata[SAMPLE_W-1:0];
               REG_CAL_Y_MAX: cfg_cal_y_max = csr_pwdata[SAMPLE_W-1:0];
               REG_SCREEN_W:  cfg_screen_w  = csr_pwdata[SIZE_W-1:0];
               REG_SCREEN_H:  cfg_screen_h  = csr_pwdata[SIZE_W-1:0];
               REG_INVERT:    cfg_invert    = csr_pwdata[1:0];
               default: ;
            endcase
         end

         // compare each result beat with the oldest expectation
         if (rsp_tvalid && rsp_tready) begin
            actual.pressed   = rsp_tuser;
            actual.screen_x  = rsp_tdata[11:0];
            actual.screen_y  = rsp_tdata[23:12];
            actual.rotated_x = rsp_tdata[35:24];
            actual.rotated_y = rsp_tdata[47:36];
            actual.pressure  = rsp_tdata[60:48];
            if (expected_reports.size() == 0) begin
               if (fault_count < 10)
                  $display("result %0d arrived with nothing expected", report_index);
               fault_count++;
            end else begin
               wanted = expected_reports.pop_front();
               if (actual !== wanted) begin
                  if (fault_count < 10) begin
                     $display("result %0d expected: pressed %0d screen %0d,%0d rotated %0d,%0d pressure %0d",
                        report_index, wanted.pressed, wanted.screen_x, wanted.screen_y,
                        wanted.rotated_x, wanted.rotated_y, wanted.pressure);
                     $display("result %0d actual:   pressed %0d screen %0d,%0d rotated %0d,%0d pressure %0d",
                        report_index, actual.pressed, actual.screen_x, actual.screen_y,
                        actual.rotated_x, actual.rotated_y, actual.pressure);
                  end
                  fault_count++;
               end
            end
            report_index++;
         end

         if (req_tvalid && req_tready)
            expected_reports.push_back(condition_readings(req_tdata));

         outstanding <= expected_reports.size();
      end
   end

endmodule

@@ tb/touch_sample_conditioner_tb.sv @@
`timescale 1ns / 100ps

module touch_sample_conditioner_tb;
   import tsc_pkg::*;

   localparam int IDLE_LIMIT      = 2000;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 80;
   localparam int LONG_HOLD       = 300;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int mismatch_count;
   int outstanding;
   int idle_cycles = 0;
   bit send_burst = 0;
   bit hold_off_request = 0;

   touch_sample_conditioner dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   touch_report_checker u_report_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("touch_sample_conditioner regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stalls, bursts with none, and one long hold-off
   initial begin
      int  gap;
      bit  take_burst;
      bit  long_hold_done;
      take_burst     = 0;
      long_hold_done = 0;
      rsp_tready     = 1'b0;
      forever begin
         if ($urandom_range(0, 15) == 0)
            take_burst = !take_burst;
         gap = take_burst ? 0 : $urandom_range(0, 3);
         if (hold_off_request && !long_hold_done) begin
            gap = LONG_HOLD;
            long_hold_done = 1;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Offer one beat after a random gap; valid stays high between back-to-back beats
   task automatic send_beat(input logic [95:0] beat);
      int gap;
      if ($urandom_range(0, 15) == 0)
         send_burst = !send_burst;
      gap = send_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= beat;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_readings(input logic [11:0] z1, z2, x0, x1, x2, y0, y1, y2);
      send_beat({y2, y1, y0, x2, x1, x0, z2, z1});
   endtask

   // Stop offering and wait until every expected result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic setup_panel(input logic [1:0] rot, input logic [11:0] x_lo, x_hi,
                              input logic [11:0] y_lo, y_hi,
                              input logic [12:0] width, height, input logic [1:0] invert);
      write_reg(REG_ROTATION, 32'(rot));
      write_reg(REG_CAL_X_MIN, 32'(x_lo));
      write_reg(REG_CAL_X_MAX, 32'(x_hi));
      write_reg(REG_CAL_Y_MIN, 32'(y_lo));
      write_reg(REG_CAL_Y_MAX, 32'(y_hi));
      write_reg(REG_SCREEN_W, 32'(width));
      write_reg(REG_SCREEN_H, 32'(height));
      write_reg(REG_INVERT, 32'(invert));
   endtask

   function automatic logic [12:0] random_screen_size();
      case ($urandom_range(0, 11))
         0:       return 13'd0;
         1:       return 13'd1;
         2:       return 13'd4096;
         3:       return 13'd8191;
         4:       return 13'($urandom_range(4097, 8191));
         default: return 13'($urandom_range(1, 4096));
      endcase
   endfunction

   // Mostly ordered calibration ranges, now and then equal or reversed
   task automatic random_setup();
      logic [11:0] a, b, c, d, t;
      a = 12'($urandom_range(0, 4095));
      b = 12'($urandom_range(0, 4095));
      c = 12'($urandom_range(0, 4095));
      d = 12'($urandom_range(0, 4095));
      if (a > b && $urandom_range(0, 7) != 0) begin
         t = a;
         a = b;
         b = t;
      end
      if (c > d && $urandom_range(0, 7) != 0) begin
         t = c;
         c = d;
         d = t;
      end
      if ($urandom_range(0, 9) == 0)
         b = a;
      setup_panel(2'($urandom_range(0, 3)), a, b, c, d,
                  random_screen_size(), random_screen_size(), 2'($urandom_range(0, 3)));
   endtask

   // Pressure mostly well above threshold; samples mostly a tight cluster per axis
   function automatic logic [95:0] random_readings();
      logic [11:0] z1, z2;
      logic [11:0] pos [6];
      int          target, centre, spread, v;
      bit          wide;
      case ($urandom_range(0, 7))
         0: begin
            z1 = 12'($urandom_range(0, 4095));
            z2 = 12'($urandom_range(0, 4095));
         end
         1: begin
            target = $urandom_range(380, 420);
            z1 = 12'($urandom_range(0, target));
            z2 = 12'(int'(z1) + 4095 - target);
         end
         2: begin
            z1 = 12'($urandom_range(0, 200));
            z2 = 12'($urandom_range(3900, 4095));
         end
         default: begin
            z1 = 12'($urandom_range(200, 4095));
            z2 = 12'($urandom_range(0, 3000));
         end
      endcase
      for (int axis = 0; axis < 2; axis++) begin
         centre = $urandom_range(0, 4095);
         spread = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 80);
         wide   = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < 3; k++) begin
            if (wide) begin
               pos[axis*3+k] = 12'($urandom_range(0, 4095));
            end else begin
               v = centre - spread + int'($urandom_range(0, 2 * spread));
               if (v < 0)
                  v = 0;
               if (v > 4095)
                  v = 4095;
               pos[axis*3+k] = 12'(v);
            end
         end
      end
      return {pos[5], pos[4], pos[3], pos[2], pos[1], pos[0], z2, z1};
   endfunction

   // Clamp low, clamp high and a mid-range point
   task automatic sweep_corners();
      send_readings(12'd4095, 12'd0, 12'd0, 12'd1, 12'd2, 12'd0, 12'd1, 12'd2);
      send_readings(12'd4095, 12'd0, 12'd4095, 12'd4094, 12'd4093,
                    12'd4095, 12'd4094, 12'd4093);
      send_readings(12'd1000, 12'd3000, 12'd1234, 12'd1300, 12'd2000,
                    12'd3000, 12'd3001, 12'd10);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default settings: threshold edges, pair choice and held values
      send_readings(12'd0, 12'd4095, 12'd500, 12'd600, 12'd700, 12'd800, 12'd900, 12'd999);
      send_readings(12'd399, 12'd4095, 12'd10, 12'd20, 12'd30, 12'd40, 12'd50, 12'd60);
      send_readings(12'd400, 12'd4095, 12'd100, 12'd200, 12'd300, 12'd0, 12'd20, 12'd10);
      send_readings(12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095,
                    12'd4095, 12'd4095, 12'd4095);
      send_readings(12'd4095, 12'd0, 12'd100, 12'd300, 12'd110, 12'd0, 12'd2000, 12'd2001);
      send_readings(12'd2000, 12'd2000, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0);
      send_readings(12'd3000, 12'd2000, 12'd0, 12'd4095, 12'd2048, 12'd4095, 12'd0, 12'd2047);
      send_readings(12'd0, 12'd4095, 12'd4095, 12'd0, 12'd1, 12'd7, 12'd8, 12'd9);

      // Quarter turn, largest screen, both axes mirrored
      drain();
      setup_panel(ROT_QUARTER, 12'd0, 12'd4095, 12'd0, 12'd4095, 13'd4096, 13'd4096, 2'd3);
      sweep_corners();

      // Equal X range, reversed Y range, zero and oversized screen
      drain();
      setup_panel(ROT_THREE_QTR, 12'd2000, 12'd2000, 12'd3000, 12'd1000,
                  13'd0, 13'd8191, 2'd1);
      sweep_corners();

      // Half turn, narrow calibration window, one-pixel width
      drain();
      setup_panel(ROT_HALF, 12'd200, 12'd3900, 12'd200, 12'd3900, 13'd1, 13'd4096, 2'd2);
      sweep_corners();

      // Fully reversed X range, one-pixel height
      drain();
      setup_panel(ROT_NONE, 12'd4095, 12'd0, 12'd0, 12'd4095, 13'd4096, 13'd1, 2'd0);
      sweep_corners();

      // Random settings, each with a run of random readings
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         random_setup();
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (phase == 3 && n == 30)
               hold_off_request <= 1'b1;
            send_beat(random_readings());
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("touch_sample_conditioner regression: pass");
      else
         $display("touch_sample_conditioner regression: fail");
      $finish;
   end

endmodule
